// File: rtl/core/alm_clk_pkg.sv
// Shared types, constants and helper functions for the alarm clock core.
package alm_clk_pkg;

    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned MINS_PER_HOUR = 60;
    localparam int unsigned HOURS_PER_DAY = 24;

    localparam logic [15:0] MS_PER_SECOND_RST  = 16'd1000;
    localparam logic [7:0]  ALARM_DURATION_RST = 8'd5;
    localparam logic [7:0]  ELAPSED_MAX        = 8'hFF;
    localparam logic [15:0] MS_COUNT_MAX       = 16'hFFFF;

    localparam logic [4:0] HOURS_RST         = 5'd0;
    localparam logic [5:0] MINUTES_RST       = 6'd59;
    localparam logic [5:0] SECONDS_RST       = 6'd0;
    localparam logic [4:0] ALARM_HOURS_RST   = 5'd0;
    localparam logic [5:0] ALARM_MINUTES_RST = 6'd59;
    localparam logic [5:0] ALARM_SECONDS_RST = 6'd5;

    // configuration register indexes
    localparam logic CFG_MS_PER_SECOND  = 1'b0;
    localparam logic CFG_ALARM_DURATION = 1'b1;

    // button bits
    localparam int unsigned BTN_SECONDS = 0;
    localparam int unsigned BTN_MINUTES = 1;
    localparam int unsigned BTN_HOURS   = 2;

    typedef enum logic [1:0] {
        KIND_RUNNING     = 2'd0,
        KIND_TIME_EDIT   = 2'd1,
        KIND_ALARM_EDIT  = 2'd2,
        KIND_UNUSED      = 2'd3
    } report_kind_t;

    typedef enum logic [1:0] {
        FIELD_NONE    = 2'd0,
        FIELD_HOURS   = 2'd1,
        FIELD_MINUTES = 2'd2,
        FIELD_SECONDS = 2'd3
    } report_field_t;

    typedef struct packed {
        logic       settings_mode;
        logic       edit_alarm;
        logic       alarm_enable;
        logic [2:0] buttons;
        logic       ms_tick;
    } item_t;

    typedef struct packed {
        logic [3:0] seconds_ones;
        logic [2:0] seconds_tens;
        logic [3:0] minutes_ones;
        logic [2:0] minutes_tens;
        logic [3:0] hours_ones;
        logic [1:0] hours_tens;
        logic       alarm_led;
        logic       report_valid;
        logic [1:0] report_kind;
        logic [1:0] report_field;
    } result_t;

    // increment and wrap to zero at the limit, no carry out
    function automatic logic [5:0] step_wrap(input logic [5:0] v, input logic [5:0] limit);
        logic [6:0] inc;
        inc = {1'b0, v} + 7'd1;
        step_wrap = (inc >= {1'b0, limit}) ? 6'd0 : inc[5:0];
    endfunction

    // tens digit of a value below 64
    function automatic logic [2:0] tens_digit(input logic [5:0] v);
        if (v >= 6'd60)      tens_digit = 3'd6;
        else if (v >= 6'd50) tens_digit = 3'd5;
        else if (v >= 6'd40) tens_digit = 3'd4;
        else if (v >= 6'd30) tens_digit = 3'd3;
        else if (v >= 6'd20) tens_digit = 3'd2;
        else if (v >= 6'd10) tens_digit = 3'd1;
        else                 tens_digit = 3'd0;
    endfunction

    function automatic logic [3:0] ones_digit(input logic [5:0] v);
        logic [5:0] t;
        t = {3'd0, tens_digit(v)};
        ones_digit = 4'(v - 6'(t * 6'd10));
    endfunction

endpackage

// File: rtl/core/alarm_clock_core.sv
// Alarm clock core: one loop pass per input beat, one display beat out per pass.
//
// s_ channel: one beat is one pass of the control loop (ms tick, button presses,
// switch levels). m_ channel: one beat per input beat with the displayed value
// as BCD digits, the alarm LED and an optional status report in tuser.
// cfg_ port: write ms_per_second (index 0) or alarm_duration (index 1) while idle.
//
// A beat in the input register is computed and registered into the output register
// when the output can advance, then offered on m_. Throughput: one beat per cycle
// while m_tready holds; the pass is combinational logic between the input and output
// registers, and the clock state updates as the beat moves into the output register.
//
// Reset (aresetn low, synchronous) sets ms_per_second to 1000, alarm_duration to 5,
// the clock to 00:59:00, the alarm to 00:59:05 and empties both stages. A stall on
// m_tready holds the output beat; the input register still takes one more beat,
// then s_tready drops until the output drains.
module alarm_clock_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // ms_tick[0], buttons[3:1], alarm_enable[4], edit_alarm[5], settings_mode[6], zero[7]
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hours_tens[1:0], hours_ones[5:2], minutes_tens[8:6], minutes_ones[12:9],
    // seconds_tens[15:13], seconds_ones[19:16], alarm_led[20], zero[23:21]
    output logic [23:0] m_tdata,
    // report_valid[0], report_kind[2:1], report_field[4:3], zero[7:5]
    output logic [7:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import alm_clk_pkg::*;

    logic        in_valid_reg, in_valid_next;
    item_t       in_item_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    logic [15:0] ms_per_second_reg;
    logic [7:0]  alarm_duration_reg;
    result_t     pass_res;
    logic        advance;
    logic        fire;
    logic        s_beat;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_beat)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            ms_per_second_reg  <= MS_PER_SECOND_RST;
            alarm_duration_reg <= ALARM_DURATION_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MS_PER_SECOND:  ms_per_second_reg  <= cfg_wdata;
                    CFG_ALARM_DURATION: alarm_duration_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat)
            in_item_reg <= item_t'(s_tdata[6:0]);
        if (fire)
            out_res_reg <= pass_res;
    end

    alm_clk_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (fire),
        .item           (in_item_reg),
        .ms_per_second  (ms_per_second_reg),
        .alarm_duration (alarm_duration_reg),
        .result         (pass_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.alarm_led,
                       out_res_reg.seconds_ones, out_res_reg.seconds_tens,
                       out_res_reg.minutes_ones, out_res_reg.minutes_tens,
                       out_res_reg.hours_ones, out_res_reg.hours_tens};
    assign m_tuser  = {3'd0, out_res_reg.report_field, out_res_reg.report_kind,
                       out_res_reg.report_valid};

    a_out_from_in: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg |=> m_tvalid)
        else $error("processed beat not presented on output");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending input beat lost during output stall");

    a_out_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg && advance |=> !m_tvalid)
        else $error("output beat without an input beat");

endmodule

// File: rtl/core/alm_clk_engine.sv
// Clock and alarm state with the single-pass update for one loop beat.
module alm_clk_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  alm_clk_pkg::item_t    item,
    input  logic [15:0]           ms_per_second,
    input  logic [7:0]            alarm_duration,
    output alm_clk_pkg::result_t  result
);
    import alm_clk_pkg::*;

    logic [15:0] ms_count_reg, ms_count_next;
    logic [4:0]  hours_reg, hours_next;
    logic [5:0]  minutes_reg, minutes_next;
    logic [5:0]  seconds_reg, seconds_next;
    logic [4:0]  alarm_hours_reg, alarm_hours_next;
    logic [5:0]  alarm_minutes_reg, alarm_minutes_next;
    logic [5:0]  alarm_seconds_reg, alarm_seconds_next;
    logic        alarm_on_reg, alarm_on_next;
    logic [7:0]  alarm_elapsed_reg, alarm_elapsed_next;
    logic        pending_reg, pending_next;

    always_comb begin
        logic [15:0] period;
        logic        sec_tick;
        logic        edit;
        logic [5:0]  h, m, s;

        ms_count_next      = ms_count_reg;
        hours_next         = hours_reg;
        minutes_next       = minutes_reg;
        seconds_next       = seconds_reg;
        alarm_hours_next   = alarm_hours_reg;
        alarm_minutes_next = alarm_minutes_reg;
        alarm_seconds_next = alarm_seconds_reg;
        alarm_on_next      = alarm_on_reg;
        alarm_elapsed_next = alarm_elapsed_reg;
        pending_next       = pending_reg;
        result             = '0;

        // button steps, settings mode only
        edit = item.settings_mode && (item.buttons != 3'd0);
        if (edit) begin
            if (item.buttons[BTN_SECONDS]) begin
                if (item.edit_alarm)
                    alarm_seconds_next = step_wrap(alarm_seconds_reg, 6'(SECS_PER_MIN));
                else
                    seconds_next = step_wrap(seconds_reg, 6'(SECS_PER_MIN));
            end
            if (item.buttons[BTN_MINUTES]) begin
                if (item.edit_alarm)
                    alarm_minutes_next = step_wrap(alarm_minutes_reg, 6'(MINS_PER_HOUR));
                else
                    minutes_next = step_wrap(minutes_reg, 6'(MINS_PER_HOUR));
            end
            if (item.buttons[BTN_HOURS]) begin
                if (item.edit_alarm)
                    alarm_hours_next = 5'(step_wrap({1'b0, alarm_hours_reg},
                                                    6'(HOURS_PER_DAY)));
                else
                    hours_next = 5'(step_wrap({1'b0, hours_reg}, 6'(HOURS_PER_DAY)));
            end
            result.report_valid = 1'b1;
            result.report_kind  = item.edit_alarm ? KIND_ALARM_EDIT : KIND_TIME_EDIT;
            result.report_field = item.buttons[BTN_HOURS]   ? FIELD_HOURS :
                                  item.buttons[BTN_MINUTES] ? FIELD_MINUTES : FIELD_SECONDS;
        end

        // prescaler; a zero period counts as one
        period = (ms_per_second == 16'd0) ? 16'd1 : ms_per_second;
        if (item.ms_tick && ms_count_reg != MS_COUNT_MAX)
            ms_count_next = ms_count_reg + 16'd1;
        sec_tick = (ms_count_next >= period);
        if (sec_tick)
            ms_count_next = 16'd0;

        // time advance, held while the time itself is being set
        if (sec_tick && !(item.settings_mode && !item.edit_alarm)) begin
            pending_next = 1'b1;
            if (seconds_next >= 6'(SECS_PER_MIN - 1)) begin
                seconds_next = 6'd0;
                if (minutes_next >= 6'(MINS_PER_HOUR - 1)) begin
                    minutes_next = 6'd0;
                    hours_next = (hours_next >= 5'(HOURS_PER_DAY - 1)) ? 5'd0
                                                                     : hours_next + 5'd1;
                end else begin
                    minutes_next = minutes_next + 6'd1;
                end
            end else begin
                seconds_next = seconds_next + 6'd1;
            end
        end

        // alarm countdown
        if (alarm_on_reg) begin
            if (sec_tick && alarm_elapsed_reg != ELAPSED_MAX)
                alarm_elapsed_next = alarm_elapsed_reg + 8'd1;
            if (alarm_elapsed_next >= alarm_duration) begin
                alarm_on_next      = 1'b0;
                alarm_elapsed_next = 8'd0;
            end
        end

        // alarm match, may refire in the pass that just cleared it
        if (item.alarm_enable && !alarm_on_next &&
            hours_next == alarm_hours_next && minutes_next == alarm_minutes_next &&
            seconds_next == alarm_seconds_next)
            alarm_on_next = 1'b1;

        // running-time report overrides an edit report
        if (!item.settings_mode && pending_next) begin
            pending_next        = 1'b0;
            result.report_valid = 1'b1;
            result.report_kind  = KIND_RUNNING;
            result.report_field = FIELD_NONE;
        end

        if (item.settings_mode && item.edit_alarm) begin
            h = {1'b0, alarm_hours_next};
            m = alarm_minutes_next;
            s = alarm_seconds_next;
        end else begin
            h = {1'b0, hours_next};
            m = minutes_next;
            s = seconds_next;
        end
        result.hours_tens   = 2'(tens_digit(h));
        result.hours_ones   = ones_digit(h);
        result.minutes_tens = tens_digit(m);
        result.minutes_ones = ones_digit(m);
        result.seconds_tens = tens_digit(s);
        result.seconds_ones = ones_digit(s);
        result.alarm_led    = alarm_on_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_count_reg      <= 16'd0;
            hours_reg         <= HOURS_RST;
            minutes_reg       <= MINUTES_RST;
            seconds_reg       <= SECONDS_RST;
            alarm_hours_reg   <= ALARM_HOURS_RST;
            alarm_minutes_reg <= ALARM_MINUTES_RST;
            alarm_seconds_reg <= ALARM_SECONDS_RST;
            alarm_on_reg      <= 1'b0;
            alarm_elapsed_reg <= 8'd0;
            pending_reg       <= 1'b0;
        end else if (step) begin
            ms_count_reg      <= ms_count_next;
            hours_reg         <= hours_next;
            minutes_reg       <= minutes_next;
            seconds_reg       <= seconds_next;
            alarm_hours_reg   <= alarm_hours_next;
            alarm_minutes_reg <= alarm_minutes_next;
            alarm_seconds_reg <= alarm_seconds_next;
            alarm_on_reg      <= alarm_on_next;
            alarm_elapsed_reg <= alarm_elapsed_next;
            pending_reg       <= pending_next;
        end
    end

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hours_reg < 5'(HOURS_PER_DAY) && minutes_reg < 6'(MINS_PER_HOUR) &&
        seconds_reg < 6'(SECS_PER_MIN))
        else $error("time fields out of range");

    a_alarm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_hours_reg < 5'(HOURS_PER_DAY) && alarm_minutes_reg < 6'(MINS_PER_HOUR) &&
        alarm_seconds_reg < 6'(SECS_PER_MIN))
        else $error("alarm fields out of range");

    a_elapsed_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !alarm_on_reg |-> alarm_elapsed_reg == 8'd0)
        else $error("alarm elapsed count nonzero while alarm is off");

    a_pending_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !item.settings_mode |=> !pending_reg)
        else $error("running report left pending in run mode");

    a_led_match: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> result.alarm_led == alarm_on_next)
        else $error("alarm LED differs from alarm state");

endmodule

// File: tb/alarm_clock_core_checker.sv
// Checker for the alarm clock core: tracks clock state per input beat and compares output beats.
`timescale 1ns / 100ps

module alarm_clock_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [7:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          mismatches,
    output int          pending
);
    import alm_clk_pkg::*;

    logic [15:0] sec_period;
    logic [7:0]  alarm_len;
    logic [15:0] ms_acc;
    logic [4:0]  clk_hh, al_hh;
    logic [5:0]  clk_mm, clk_ss, al_mm, al_ss;
    logic        al_active;
    logic [7:0]  al_secs;
    logic        run_note_due;

    result_t display_q[$];
    int      miss_cnt = 0;
    int      queued = 0;

    assign mismatches = miss_cnt;
    assign pending    = queued;

    function automatic logic [5:0] next_wrapped(input logic [5:0] v, input int unsigned lim);
        int unsigned nxt;
        nxt = v + 1;
        return (nxt >= lim) ? 6'd0 : 6'(nxt);
    endfunction

    // one pass of the control loop; updates the tracked state
    task automatic clock_pass(input item_t it, output result_t r);
        logic        sec_tick;
        logic [16:0] per;
        int          h, m, s;
        r = '0;
        sec_tick = 1'b0;

        if (it.settings_mode && it.buttons != 3'd0) begin
            if (it.buttons[BTN_SECONDS]) begin
                if (it.edit_alarm) al_ss = next_wrapped(al_ss, SECS_PER_MIN);
                else clk_ss = next_wrapped(clk_ss, SECS_PER_MIN);
            end
            if (it.buttons[BTN_MINUTES]) begin
                if (it.edit_alarm) al_mm = next_wrapped(al_mm, MINS_PER_HOUR);
                else clk_mm = next_wrapped(clk_mm, MINS_PER_HOUR);
            end
            if (it.buttons[BTN_HOURS]) begin
                if (it.edit_alarm) al_hh = 5'(next_wrapped({1'b0, al_hh}, HOURS_PER_DAY));
                else clk_hh = 5'(next_wrapped({1'b0, clk_hh}, HOURS_PER_DAY));
            end
            r.report_valid = 1'b1;
            r.report_kind  = it.edit_alarm ? KIND_ALARM_EDIT : KIND_TIME_EDIT;
            r.report_field = it.buttons[BTN_HOURS]   ? FIELD_HOURS :
                             it.buttons[BTN_MINUTES] ? FIELD_MINUTES : FIELD_SECONDS;
        end

        // a zero period behaves as one
        per = (sec_period == 16'd0) ? 17'd1 : {1'b0, sec_period};
        if (it.ms_tick && ms_acc != MS_COUNT_MAX) ms_acc = ms_acc + 16'd1;
        if ({1'b0, ms_acc} >= per) begin
            ms_acc   = 16'd0;
            sec_tick = 1'b1;
        end

        // time stands still while it is being edited
        if (sec_tick && !(it.settings_mode && !it.edit_alarm)) begin
            run_note_due = 1'b1;
            clk_ss = clk_ss + 6'd1;
            if (clk_ss >= SECS_PER_MIN) begin
                clk_ss = 6'd0;
                clk_mm = clk_mm + 6'd1;
            end
            if (clk_mm >= MINS_PER_HOUR) begin
                clk_mm = 6'd0;
                clk_hh = clk_hh + 5'd1;
            end
            if (clk_hh >= HOURS_PER_DAY) clk_hh = 5'd0;
        end

        if (al_active) begin
            if (sec_tick && al_secs != ELAPSED_MAX) al_secs = al_secs + 8'd1;
            if (al_secs >= alarm_len) begin
                al_active = 1'b0;
                al_secs   = 8'd0;
            end
        end

        if (it.alarm_enable && !al_active &&
            clk_hh == al_hh && clk_mm == al_mm && clk_ss == al_ss)
            al_active = 1'b1;

        if (!it.settings_mode && run_note_due) begin
            run_note_due   = 1'b0;
            r.report_valid = 1'b1;
            r.report_kind  = KIND_RUNNING;
            r.report_field = FIELD_NONE;
        end

        if (it.settings_mode && it.edit_alarm) begin
            h = al_hh;
            m = al_mm;
            s = al_ss;
        end else begin
            h = clk_hh;
            m = clk_mm;
            s = clk_ss;
        end
        r.hours_tens   = 2'(h / 10);
        r.hours_ones   = 4'(h % 10);
        r.minutes_tens = 3'(m / 10);
        r.minutes_ones = 4'(m % 10);
        r.seconds_tens = 3'(s / 10);
        r.seconds_ones = 4'(s % 10);
        r.alarm_led    = al_active;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            miss_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want, got;
        item_t   it;
        if (!aresetn) begin
            sec_period   = MS_PER_SECOND_RST;
            alarm_len    = ALARM_DURATION_RST;
            ms_acc       = '0;
            clk_hh       = HOURS_RST;
            clk_mm       = MINUTES_RST;
            clk_ss       = SECONDS_RST;
            al_hh        = ALARM_HOURS_RST;
            al_mm        = ALARM_MINUTES_RST;
            al_ss        = ALARM_SECONDS_RST;
            al_active    = 1'b0;
            al_secs      = '0;
            run_note_due = 1'b0;
            display_q.delete();
        end else begin
            // compare before queuing: a beat taken in this edge cannot leave in it
            if (m_tvalid && m_tready) begin
                got = '0;
                got.hours_tens   = m_tdata[1:0];
                got.hours_ones   = m_tdata[5:2];
                got.minutes_tens = m_tdata[8:6];
                got.minutes_ones = m_tdata[12:9];
                got.seconds_tens = m_tdata[15:13];
                got.seconds_ones = m_tdata[19:16];
                got.alarm_led    = m_tdata[20];
                got.report_valid = m_tuser[0];
                got.report_kind  = m_tuser[2:1];
                got.report_field = m_tuser[4:3];
                if (display_q.size() == 0) begin
                    miss_cnt++;
                    $display("%0t: output beat with none expected, actual tdata=%h tuser=%h",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = display_q.pop_front();
                    check_field("hours_tens",   want.hours_tens,   got.hours_tens);
                    check_field("hours_ones",   want.hours_ones,   got.hours_ones);
                    check_field("minutes_tens", want.minutes_tens, got.minutes_tens);
                    check_field("minutes_ones", want.minutes_ones, got.minutes_ones);
                    check_field("seconds_tens", want.seconds_tens, got.seconds_tens);
                    check_field("seconds_ones", want.seconds_ones, got.seconds_ones);
                    check_field("alarm_led",    want.alarm_led,    got.alarm_led);
                    check_field("report_valid", want.report_valid, got.report_valid);
                    check_field("report_kind",  want.report_kind,  got.report_kind);
                    check_field("report_field", want.report_field, got.report_field);
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_MS_PER_SECOND) sec_period = cfg_wdata;
                else alarm_len = cfg_wdata[7:0];
            end
            if (s_tvalid && s_tready) begin
                it = item_t'(s_tdata[6:0]);
                clock_pass(it, want);
                display_q.push_back(want);
            end
        end
        queued = display_q.size();
    end

endmodule

// File: tb/tb_alarm_clock_core.sv
// Top of the alarm clock core testbench: clock, reset, stimulus phases and verdict.
`timescale 1ns / 100ps

module tb_alarm_clock_core;
    import alm_clk_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    int mismatches;
    int pending;
    int cycle_cnt = 0;
    int beats_in = 0;
    int beats_out = 0;
    int shown_h, shown_m, shown_s;
    int stall_left = 0;
    bit jitter = 0;
    int period_now = 1000;
    int dur_now = 5;
    int al_h, al_m, al_s;
    bit alarm_known = 0;

    alarm_clock_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    alarm_clock_core_checker i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: stall in random bursts while jitter is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (jitter && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // keep the last displayed value so the stimulus can steer the clock
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_out <= beats_out + 1;
            shown_h   <= int'(m_tdata[1:0]) * 10 + int'(m_tdata[5:2]);
            shown_m   <= int'(m_tdata[8:6]) * 10 + int'(m_tdata[12:9]);
            shown_s   <= int'(m_tdata[15:13]) * 10 + int'(m_tdata[19:16]);
        end
    end

    task automatic send(input item_t it);
        if (jitter && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it};
        do @(posedge aclk); while (!s_tready);
        beats_in++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_out != beats_in);
    endtask

    task automatic write_reg(input logic idx, input int value);
        drain();
        repeat (3) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 16'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MS_PER_SECOND) period_now = value;
        else dur_now = value;
    endtask

    // read the time or the alarm from the display, then step it to h:m:s
    task automatic dial_in(input logic to_alarm, input int h, input int m, input int s);
        item_t it;
        int    nh, nm, ns;
        it = '0;
        it.settings_mode = 1'b1;
        it.edit_alarm    = to_alarm;
        send(it);
        drain();
        nh = (h - shown_h + 24) % 24;
        nm = (m - shown_m + 60) % 60;
        ns = (s - shown_s + 60) % 60;
        while (nh + nm + ns > 0) begin
            it.buttons = 3'($urandom_range(1, 7)) & {nh > 0, nm > 0, ns > 0};
            if (it.buttons != 3'd0) begin
                it.ms_tick      = to_alarm ? 1'b0 : 1'($urandom_range(0, 1));
                it.alarm_enable = !to_alarm;
                send(it);
                if (it.buttons[BTN_HOURS])   nh--;
                if (it.buttons[BTN_MINUTES]) nm--;
                if (it.buttons[BTN_SECONDS]) ns--;
            end
        end
    endtask

    task automatic run_clock(input int n);
        item_t it;
        repeat (n) begin
            it = '0;
            it.settings_mode = ($urandom_range(0, 9) == 0);
            it.edit_alarm    = 1'($urandom_range(0, 1));
            it.buttons       = 3'($urandom_range(0, 7));
            it.alarm_enable  = ($urandom_range(0, 7) != 0);
            it.ms_tick       = ($urandom_range(0, 3) != 0);
            send(it);
        end
    endtask

    task automatic noise(input int n);
        repeat (n) send(item_t'(7'($urandom_range(0, 127))));
    endtask

    // set the time a few seconds short of the alarm and let it run into it
    task automatic alarm_episode();
        int k, n, per;
        if (!alarm_known || $urandom_range(0, 2) == 0) begin
            al_h = $urandom_range(0, 23);
            al_m = $urandom_range(0, 59);
            al_s = $urandom_range(0, 59);
            dial_in(1'b1, al_h, al_m, al_s);
            alarm_known = 1;
        end
        k = $urandom_range(0, (al_s < 6) ? al_s : 6);
        dial_in(1'b0, al_h, al_m, al_s - k);
        per = (period_now == 0) ? 1 : period_now;
        n = per * (k + dur_now + 3);
        if (n > 72) n = 72;
        run_clock(n + n / 3);
    endtask

    initial begin : stimulus
        item_t it;
        int    ms_tab [6];
        int    dur_tab [6];
        ms_tab  = '{1, 0, 65535, 1, 4, 2};
        dur_tab = '{1, 0, 255, 255, 9, 3};

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_MS_PER_SECOND;
        cfg_wdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // presses in run mode are dropped
        it = '0;
        it.buttons = 3'b111;
        it.ms_tick = 1'b1;
        it.alarm_enable = 1'b1;
        send(it);
        // time edits: each button alone, all together, none
        it = '0;
        it.settings_mode = 1'b1;
        foreach (ms_tab[i]) begin
            if (i < 5) begin
                it.buttons = (i == 3) ? 3'b111 : (i == 4) ? 3'b000 : 3'(1 << i);
                send(it);
            end
        end
        // alarm edits with every button mix; hours ranks over minutes
        it.edit_alarm = 1'b1;
        for (int b = 1; b < 8; b++) begin
            it.buttons = 3'(b);
            it.ms_tick = b[0];
            send(it);
        end
        // build up the prescaler count, then lower the period below it
        it = '0;
        it.ms_tick = 1'b1;
        repeat (10) send(it);
        write_reg(CFG_MS_PER_SECOND, 3);
        run_clock(4);
        // full carry from 23:59:58 into an alarm just past midnight
        dial_in(1'b1, 0, 0, 1);
        dial_in(1'b0, 23, 59, 58);
        it = '0;
        it.ms_tick = 1'b1;
        it.alarm_enable = 1'b1;
        repeat (30) send(it);

        foreach (ms_tab[p]) begin
            write_reg(CFG_MS_PER_SECOND, ms_tab[p]);
            write_reg(CFG_ALARM_DURATION, dur_tab[p]);
            jitter = (p != 5) && ($urandom_range(0, 3) != 0);
            alarm_episode();
            noise(30);
            alarm_episode();
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
